// ----- rtl/core/pcsw_pkg.sv -----
// package for the pen convolution stroke walker
// commands, status codes, controller/datapath command and status structs
package pcsw_pkg;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_BEGIN  = 3'd2,
      CMD_POINT  = 3'd3,
      CMD_END    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_HULL    = 2'd0,
      ST_NO_VERT = 2'd1,
      ST_FULL    = 2'd2,
      ST_LIMIT   = 2'd3
   } status_type;

   localparam int WALK_LIMIT = 31;

   typedef enum logic [1:0] {
      HULL_ZERO  = 2'd0,
      HULL_POINT = 2'd1,
      HULL_VERT  = 2'd2
   } hull_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         load_item;
      logic         rd_issue;
      logic         rd_cur;
      logic         eval;
      logic         scan_begin;
      logic         scan_next;
      logic         step_fwd;
      logic         step_back;
      logic         set_active;
      logic         zero_active;
      logic         latch_point;
      logic         pending_clr;
      hull_sel_type hull_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ccw_of_next;
      logic cw_of_prev;
      logic scan_done;
      logic pen_empty;
      logic pen_full;
      logic pending_valid;
   } dp_stat_type;

endpackage

// ----- rtl/core/pcsw_datapath.sv -----
// datapath: pen memory, active vertex, pending point, cross product compare
// uses pcsw_pkg
module pcsw_datapath #(
   parameter int MAX_PEN_VERTICES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pcsw_pkg::dp_cmd_type cmd,
   output pcsw_pkg::dp_stat_type stat,
   input  logic [2:0]           req_cmd,
   input  logic signed [31:0]   req_coord_x,
   input  logic signed [31:0]   req_coord_y,
   input  logic signed [31:0]   req_slope_dx,
   input  logic signed [31:0]   req_slope_dy,
   input  logic                 req_reverse_dir,
   output logic signed [31:0]   hull_x,
   output logic signed [31:0]   hull_y
);
   localparam int AW = $clog2(MAX_PEN_VERTICES);
   localparam int SW = AW + 1;

   logic [31:0] mem_x [MAX_PEN_VERTICES];
   logic [31:0] mem_y [MAX_PEN_VERTICES];

   logic [SW-1:0] size_ff;
   logic [AW-1:0] active_ff, cur_ff;
   logic [31:0]   pend_x_ff, pend_y_ff, pt_x_ff, pt_y_ff;
   logic          pend_v_ff, neg_ff;
   logic [31:0]   sx_ff, sy_ff;
   logic [2:0]    cmd_ff;
   logic [31:0]   in_x_ff, in_y_ff;
   logic [31:0]   ax_ff, ay_ff, nx_ff, ny_ff;
   logic [31:0]   cx_ff, cy_ff, wx_ff, wy_ff;
   logic signed [63:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [1:0]    ph_ff;
   logic [AW-1:0] nidx, pidx, rd_idx;
   logic [SW-1:0] cur_ext;

   assign cur_ext = {1'b0, cur_ff};
   assign nidx = (cur_ext + SW'(1) >= size_ff) ? '0 : cur_ff + AW'(1);
   assign pidx = (cur_ff == '0) ? AW'(size_ff - SW'(1)) : cur_ff - AW'(1);

   // three reads in order: current, next, previous
   always_comb begin
      unique case (ph_ff)
         2'd0:    rd_idx = cur_ff;
         2'd1:    rd_idx = nidx;
         default: rd_idx = pidx;
      endcase
   end

   logic [31:0] rdx_ff, rdy_ff;
   always_ff @(posedge clock) begin
      rdx_ff <= mem_x[rd_idx];
      rdy_ff <= mem_y[rd_idx];
      if (cmd.load_item && req_cmd == pcsw_pkg::CMD_APPEND && size_ff < SW'(MAX_PEN_VERTICES))
      begin
         mem_x[size_ff[AW-1:0]] <= req_coord_x;
         mem_y[size_ff[AW-1:0]] <= req_coord_y;
      end
   end

   logic [31:0] ssx, ssy;
   always_comb begin
      ssx = req_slope_dx;
      ssy = req_slope_dy;
      if (req_cmd == pcsw_pkg::CMD_POINT) begin
         ssx = req_coord_x - pend_x_ff;
         ssy = req_coord_y - pend_y_ff;
      end else if ((req_cmd == pcsw_pkg::CMD_BEGIN && req_reverse_dir) ||
                   (req_cmd == pcsw_pkg::CMD_END && neg_ff)) begin
         ssx = 32'd0 - req_slope_dx;
         ssy = 32'd0 - req_slope_dy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= '0;
         active_ff <= '0;
         cur_ff    <= '0;
         pend_v_ff <= 1'b0;
         neg_ff    <= 1'b0;
         pend_x_ff <= '0;
         pend_y_ff <= '0;
         ph_ff     <= 2'd0;
      end else begin
         if (cmd.load_item) begin
            cmd_ff  <= req_cmd;
            in_x_ff <= req_coord_x;
            in_y_ff <= req_coord_y;
            sx_ff   <= ssx;
            sy_ff   <= ssy;
            pt_x_ff <= pend_x_ff;
            pt_y_ff <= pend_y_ff;
            cur_ff  <= ({1'b0, active_ff} >= size_ff) ? '0 : active_ff;
            unique case (req_cmd)
               pcsw_pkg::CMD_CLEAR: size_ff <= '0;
               pcsw_pkg::CMD_APPEND:
                  if (size_ff < SW'(MAX_PEN_VERTICES)) size_ff <= size_ff + SW'(1);
               pcsw_pkg::CMD_BEGIN: begin
                  neg_ff    <= req_reverse_dir;
                  pend_v_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (cmd.rd_issue) ph_ff <= ph_ff + 2'd1;
         if (cmd.rd_cur) ph_ff <= 2'd0;
         if (ph_ff == 2'd1) begin
            ax_ff <= rdx_ff;
            ay_ff <= rdy_ff;
         end
         if (ph_ff == 2'd2) begin
            nx_ff <= rdx_ff;
            ny_ff <= rdy_ff;
         end
         if (ph_ff == 2'd3) begin
            cx_ff <= nx_ff - ax_ff;
            cy_ff <= ny_ff - ay_ff;
            wx_ff <= ax_ff - rdx_ff;
            wy_ff <= ay_ff - rdy_ff;
         end
         if (cmd.eval) begin
            p1_ff <= $signed(cy_ff) * $signed(sx_ff);
            p2_ff <= $signed(sy_ff) * $signed(cx_ff);
            p3_ff <= $signed(wy_ff) * $signed(sx_ff);
            p4_ff <= $signed(sy_ff) * $signed(wx_ff);
         end
         if (cmd.scan_begin) cur_ff <= '0;
         if (cmd.scan_next) cur_ff <= cur_ff + AW'(1);
         if (cmd.step_fwd) cur_ff <= nidx;
         if (cmd.step_back) cur_ff <= pidx;
         if (cmd.set_active) active_ff <= cur_ff;
         if (cmd.zero_active) active_ff <= '0;
         if (cmd.latch_point) begin
            pend_x_ff <= in_x_ff;
            pend_y_ff <= in_y_ff;
            pend_v_ff <= 1'b1;
         end
         if (cmd.pending_clr) pend_v_ff <= 1'b0;
      end
   end

   assign stat.ccw_of_next   = !(p1_ff > p2_ff);
   assign stat.cw_of_prev    = p3_ff > p4_ff;
   assign stat.scan_done     = (cur_ext + SW'(1) >= size_ff);
   assign stat.pen_empty     = (size_ff == '0);
   assign stat.pen_full      = (size_ff >= SW'(MAX_PEN_VERTICES));
   assign stat.pending_valid = pend_v_ff;

   // hull point uses the pending point at end, else the pending point captured at load
   logic [31:0] bx, by;
   assign bx = (cmd_ff == pcsw_pkg::CMD_END) ? pend_x_ff : pt_x_ff;
   assign by = (cmd_ff == pcsw_pkg::CMD_END) ? pend_y_ff : pt_y_ff;

   always_comb begin
      unique case (cmd.hull_sel)
         pcsw_pkg::HULL_POINT: begin
            hull_x = bx;
            hull_y = by;
         end
         pcsw_pkg::HULL_VERT: begin
            hull_x = bx + ax_ff;
            hull_y = by + ay_ff;
         end
         default: begin
            hull_x = '0;
            hull_y = '0;
         end
      endcase
   end
endmodule

// ----- rtl/core/pcsw_control.sv -----
// controller state machine: sequences reads, compares, walk and results
// uses pcsw_pkg
module pcsw_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_cmd,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last,
   output pcsw_pkg::dp_cmd_type  dcmd,
   input  pcsw_pkg::dp_stat_type stat
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_RD0, S_RD1, S_RD2, S_RD3, S_MUL, S_DEC, S_OUT, S_WAIT
   } state_type;

   state_type state_ff;
   logic [2:0] cmd_ff;
   logic [5:0] steps_ff;
   logic       scan_ff, stop_ff, rv_ff, last_ff, full_ff;
   logic [1:0] st_ff;
   pcsw_pkg::hull_sel_type sel_ff;

   logic accept, limit;
   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign limit = (steps_ff == 6'(pcsw_pkg::WALK_LIMIT + 1));

   always_comb begin
      dcmd = '0;
      dcmd.hull_sel = sel_ff;
      dcmd.load_item = accept;
      dcmd.rd_issue = (state_ff == S_RD0) || (state_ff == S_RD1) || (state_ff == S_RD2);
      dcmd.rd_cur = (state_ff == S_RD3);
      dcmd.eval = (state_ff == S_MUL);
      if (state_ff == S_DISPATCH && cmd_ff == pcsw_pkg::CMD_BEGIN) dcmd.scan_begin = 1'b1;
      if (state_ff == S_DISPATCH && cmd_ff == pcsw_pkg::CMD_POINT) dcmd.latch_point = 1'b1;
      if (state_ff == S_DISPATCH && cmd_ff == pcsw_pkg::CMD_BEGIN && stat.pen_empty)
         dcmd.zero_active = 1'b1;
      if (state_ff == S_RD3 && !scan_ff && limit) dcmd.set_active = 1'b1;
      if (state_ff == S_DEC) begin
         if (scan_ff) begin
            if (!stat.ccw_of_next && !stat.cw_of_prev) dcmd.set_active = 1'b1;
            else if (stat.scan_done) dcmd.zero_active = 1'b1;
            else dcmd.scan_next = 1'b1;
         end else begin
            if (stat.ccw_of_next) dcmd.step_fwd = 1'b1;
            else if (stat.cw_of_prev) dcmd.step_back = 1'b1;
            else dcmd.set_active = 1'b1;
         end
      end
      if (state_ff == S_DISPATCH && cmd_ff == pcsw_pkg::CMD_END) dcmd.pending_clr = 1'b1;
   end

   assign rsp_valid  = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_last   = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         scan_ff  <= 1'b0;
         stop_ff  <= 1'b0;
         full_ff  <= 1'b0;
         steps_ff <= '0;
         sel_ff   <= pcsw_pkg::HULL_ZERO;
         st_ff    <= pcsw_pkg::ST_HULL;
         last_ff  <= 1'b0;
         cmd_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (accept) begin
               cmd_ff   <= req_cmd;
               full_ff  <= stat.pen_full;
               state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               steps_ff <= '0;
               if (cmd_ff == pcsw_pkg::CMD_APPEND && full_ff) begin
                  sel_ff <= pcsw_pkg::HULL_ZERO;
                  st_ff <= pcsw_pkg::ST_FULL;
                  last_ff <= 1'b1;
                  stop_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else if (cmd_ff == pcsw_pkg::CMD_BEGIN) begin
                  scan_ff <= 1'b1;
                  if (stat.pen_empty) begin
                     sel_ff <= pcsw_pkg::HULL_ZERO;
                     st_ff <= pcsw_pkg::ST_NO_VERT;
                     last_ff <= 1'b1;
                     stop_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     stop_ff <= 1'b0;
                     state_ff <= S_RD0;
                  end
               end else if ((cmd_ff == pcsw_pkg::CMD_POINT || cmd_ff == pcsw_pkg::CMD_END)
                            && stat.pending_valid) begin
                  scan_ff <= 1'b0;
                  if (stat.pen_empty) begin
                     sel_ff <= pcsw_pkg::HULL_POINT;
                     st_ff <= pcsw_pkg::ST_NO_VERT;
                     last_ff <= 1'b1;
                     stop_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     stop_ff <= 1'b0;
                     state_ff <= S_RD0;
                  end
               end else state_ff <= S_IDLE;
            end
            S_RD0: state_ff <= S_RD1;
            S_RD1: state_ff <= S_RD2;
            S_RD2: state_ff <= S_RD3;
            S_RD3: begin
               if (!scan_ff && limit) begin
                  sel_ff <= pcsw_pkg::HULL_VERT;
                  st_ff <= pcsw_pkg::ST_LIMIT;
                  last_ff <= 1'b1;
                  stop_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else state_ff <= S_MUL;
            end
            S_MUL: state_ff <= S_DEC;
            S_DEC: begin
               if (scan_ff) begin
                  if (!stat.ccw_of_next && !stat.cw_of_prev) state_ff <= S_IDLE;
                  else if (stat.scan_done) begin
                     sel_ff <= pcsw_pkg::HULL_ZERO;
                     st_ff <= pcsw_pkg::ST_NO_VERT;
                     last_ff <= 1'b1;
                     stop_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else state_ff <= S_RD0;
               end else begin
                  // emit the current vertex, last when the walk stops here
                  sel_ff <= pcsw_pkg::HULL_VERT;
                  st_ff <= pcsw_pkg::ST_HULL;
                  state_ff <= S_OUT;
                  if (stat.ccw_of_next || stat.cw_of_prev) begin
                     steps_ff <= steps_ff + 6'd1;
                     last_ff <= 1'b0;
                  end else begin
                     last_ff <= 1'b1;
                     stop_ff <= 1'b1;
                  end
               end
            end
            S_OUT: begin
               rv_ff <= 1'b1;
               state_ff <= S_WAIT;
            end
            S_WAIT: if (rsp_ready) begin
               rv_ff <= 1'b0;
               state_ff <= stop_ff ? S_IDLE : S_RD0;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
   a_steps: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= 6'(pcsw_pkg::WALK_LIMIT + 1)) else $error("walk overran");
`endif
endmodule

// ----- rtl/core/pen_convolution_stroke_walker.sv -----
// top level of the pen convolution stroke walker
// instantiates pcsw_control and pcsw_datapath, uses pcsw_pkg
// One transaction at a time. Each pen vertex visit steps through the read
// states S_RD0 to S_RD3 for registered memory reads, a multiply state and a
// compare state. A begin scan tries vertices in turn, and a status result goes
// out when no vertex qualifies. A point or end item emits hull points one
// result at a time, ending with a walk limit point if the walk runs too long,
// each result holding until rsp_ready. Clear and append give no result; an
// append to a full pen gives a full status result, subject to output stalls.
module pen_convolution_stroke_walker #(
   parameter int MAX_PEN_VERTICES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_slope_dx,
   input  logic signed [31:0] req_slope_dy,
   input  logic               req_reverse_dir,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_hull_x,
   output logic signed [31:0] rsp_hull_y,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   pcsw_pkg::dp_cmd_type  dcmd;
   pcsw_pkg::dp_stat_type stat;

   pcsw_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_cmd,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_last,
      .dcmd, .stat
   );

   pcsw_datapath #(.MAX_PEN_VERTICES(MAX_PEN_VERTICES)) u_dp (
      .clock, .reset, .cmd(dcmd), .stat,
      .req_cmd, .req_coord_x, .req_coord_y, .req_slope_dx, .req_slope_dy,
      .req_reverse_dir, .hull_x(rsp_hull_x), .hull_y(rsp_hull_y)
   );
endmodule
